>>> hw/rtl/llcfc_pkg.sv
// ----------------------------------------------------------------------------
// LLC frame check package
// Word types, CRC-24 constants and the byte-wide CRC update.
// ----------------------------------------------------------------------------
package llcfc_pkg;

    localparam logic [23:0] CRC_INIT  = 24'hFFFFFF;
    localparam logic [23:0] CRC_POLY  = 24'hAD85DD;
    localparam logic [2:0]  COUNT_MAX = 3'd4;

    localparam logic [1:0] CRC_OK    = 2'd0;
    localparam logic [1:0] CRC_BAD   = 2'd1;
    localparam logic [1:0] CRC_SHORT = 2'd2;

    localparam logic [1:0] FMT_I  = 2'd0;
    localparam logic [1:0] FMT_S  = 2'd1;
    localparam logic [1:0] FMT_UI = 2'd2;
    localparam logic [1:0] FMT_U  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  crc_verdict;
        logic        pd_error;
        logic        cr_bit;
        logic [3:0]  sapi;
        logic [1:0]  hdr_format;
        logic [8:0]  seq_number;
        logic [1:0]  low_bits;
        logic [3:0]  unnumbered_command;
        logic        poll_final;
        logic        deliver_by_sapi;
        logic [23:0] computed_fcs;
        logic [23:0] received_fcs;
    } t_out_word;

    function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {16'h0000, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/llc_frame_header_and_fcs_checker_core.sv
// ----------------------------------------------------------------------------
// LLC frame header and FCS checker
// Checks the CRC-24 frame check sequence and decodes the LLC header.
// ----------------------------------------------------------------------------
// Bytes of a frame arrive one word per cycle with a last-byte mark. Each word
// passes an input register, then the CRC and header logic, so a word is taken
// every cycle except while the last byte waits, and the result word is
// registered as the last byte leaves the input register. Only the last byte
// waits on the output register; the CRC-24 byte update sets the critical path.
// The final three bytes are the received FCS (little endian); frames under
// three bytes report the FCS as not computed.
module llc_frame_header_and_fcs_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  llcfc_pkg::t_in_word i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output llcfc_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import llcfc_pkg::*;

    logic        r_s1_vld, n_s1_vld;
    t_in_word    r_s1;
    logic        r_out_vld, n_out_vld;
    t_out_word   r_out, n_out;
    logic        r_ign_ciph;
    logic [2:0]  r_cnt, n_cnt;
    logic [7:0]  r_addr, n_addr;
    logic [15:0] r_ctrl, n_ctrl;
    logic [7:0]  r_tail [3];
    logic        go;
    logic        fin;
    logic [2:0]  cnt_new;
    logic [23:0] crc_next;
    logic [7:0]  cb;

    assign go          = r_s1_vld && (!r_s1.last_byte || !r_out_vld || i_out_ready);
    assign fin         = go && r_s1.last_byte;
    assign o_in_ready  = !r_s1_vld || go;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    llcfc_crc24 u_crc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (go && (r_cnt >= 3'd3)),
        .i_clr      (fin),
        .i_byte     (r_tail[0]),
        .o_crc_next (crc_next)
    );

    always_comb begin
        n_s1_vld = i_in_valid ? 1'b1 : (go ? 1'b0 : r_s1_vld);
        if (!o_in_ready) begin
            n_s1_vld = r_s1_vld;
        end
        n_out_vld = fin ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
    end

    always_comb begin
        cnt_new = (r_cnt < COUNT_MAX) ? r_cnt + 3'd1 : COUNT_MAX;
        n_addr  = (r_cnt == 3'd0) ? r_s1.data_byte : r_addr;
        n_ctrl  = r_ctrl;
        if (r_cnt == 3'd1) begin
            n_ctrl = {r_s1.data_byte, 8'h00};
        end else if (r_cnt == 3'd2) begin
            n_ctrl = {r_ctrl[15:8], r_s1.data_byte};
        end
        n_cnt = cnt_new;

        n_out = '0;
        if (cnt_new >= 3'd3) begin
            n_out.computed_fcs = ~crc_next;
            n_out.received_fcs = {r_s1.data_byte, r_tail[2], r_tail[1]};
            n_out.crc_verdict  = (n_out.computed_fcs == n_out.received_fcs) ?
                                 CRC_OK : CRC_BAD;
        end else begin
            n_out.crc_verdict = CRC_SHORT;
        end

        cb = n_ctrl[15:8];
        n_out.pd_error = n_addr[7];
        if (!n_addr[7]) begin
            n_out.cr_bit = n_addr[6];
            n_out.sapi   = n_addr[3:0];
            priority if (cb < 8'h80) begin
                n_out.hdr_format = FMT_I;
            end else if (cb < 8'hC0) begin
                n_out.hdr_format = FMT_S;
            end else if (cb < 8'hE0) begin
                n_out.hdr_format = FMT_UI;
            end else begin
                n_out.hdr_format = FMT_U;
            end
            unique case (n_out.hdr_format)
                FMT_S, FMT_UI: begin
                    n_out.seq_number = n_ctrl[10:2];
                    n_out.low_bits   = n_ctrl[1:0];
                    if (n_out.hdr_format == FMT_UI) begin
                        n_out.deliver_by_sapi = (r_ign_ciph && n_out.crc_verdict == CRC_OK)
                                                || !n_ctrl[1];
                    end
                end
                FMT_U: begin
                    n_out.unnumbered_command = cb[3:0];
                    n_out.poll_final         = cb[4];
                end
                default: begin
                end
            endcase
        end

        if (fin) begin
            n_cnt  = 3'd0;
            n_addr = 8'h00;
            n_ctrl = 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_ign_ciph <= 1'b0;
            r_cnt      <= 3'd0;
            r_addr     <= 8'h00;
            r_ctrl     <= 16'h0000;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_ign_ciph <= i_cfg_data;
            end
            if (go) begin
                r_cnt  <= n_cnt;
                r_addr <= n_addr;
                r_ctrl <= n_ctrl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= i_in_word;
        end
        if (go) begin
            r_tail[0] <= r_tail[1];
            r_tail[1] <= r_tail[2];
            r_tail[2] <= r_s1.data_byte;
        end
        if (fin) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hw/rtl/llcfc_crc24.sv
// ----------------------------------------------------------------------------
// LLC frame check CRC-24
// Reflected CRC-24 register, one byte per update, with frame clear.
// ----------------------------------------------------------------------------
module llcfc_crc24 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_upd,
    input  logic        i_clr,
    input  logic [7:0]  i_byte,
    output logic [23:0] o_crc_next
);
    import llcfc_pkg::*;

    logic [23:0] r_crc;
    logic [23:0] n_crc;

    assign o_crc_next = i_upd ? crc_byte(r_crc, i_byte) : r_crc;

    always_comb begin
        n_crc = i_clr ? CRC_INIT : o_crc_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule

>>> hw/rtl/llcfc_checker.sv
// ----------------------------------------------------------------------------
// LLC frame check port checker
// Port-level properties of the checker core, bound to the top level.
// ----------------------------------------------------------------------------
module llcfc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input llcfc_pkg::t_out_word o_out_word
);
    import llcfc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    a_fcs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.crc_verdict <= CRC_SHORT)
        else $error("bad fcs status");

    a_pd_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.pd_error |-> o_out_word.sapi == 4'd0
        && !o_out_word.cr_bit && o_out_word.hdr_format == FMT_I
        && !o_out_word.deliver_by_sapi)
        else $error("header fields set on pd error");

    a_short_fcs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.crc_verdict == CRC_SHORT |->
        o_out_word.computed_fcs == 24'd0 && o_out_word.received_fcs == 24'd0)
        else $error("fcs fields set on short frame");

    a_deliver_ui: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.deliver_by_sapi |-> o_out_word.hdr_format == FMT_UI)
        else $error("delivery on non-UI frame");

endmodule

bind llc_frame_header_and_fcs_checker_core llcfc_checker u_llcfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
